### src/tks_pkg.sv
//------------------------------------------------------------------------------
// tks_pkg
// Shared types and constants for the topological sort engine.
//------------------------------------------------------------------------------
`default_nettype none

package tks_pkg;

   // node indices are 5 bits wide on both channels, so the node range is fixed
   localparam int MAX_NODES     = 32;
   localparam int NODE_W        = 5;
   localparam int COUNT_W       = 6;   // holds 0 .. MAX_NODES
   localparam int MAX_EDGES_DEF = 64;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_ADD   = 2'd1,
      OP_SORT  = 2'd2
   } opcode_type;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_COUNT  = 6'b000010,
      ST_SEED   = 6'b000100,
      ST_POP    = 6'b001000,
      ST_SCAN   = 6'b010000,
      ST_STATUS = 6'b100000
   } state_type;

endpackage

`default_nettype wire

### src/topological_sort_kahn.sv
//------------------------------------------------------------------------------
// topological_sort_kahn
// Edge store plus Kahn topological sort with a last-in first-out work stack.
//------------------------------------------------------------------------------
// Clear and add-edge beats produce no result. A sort beat runs a count pass over
// all stored edges, a seed pass over the nodes, and one walk over all edges per
// pop, one edge-store read per cycle, before the status beat; output stalls add
// to its run time and hold the pops.
// Throughput: one beat at a time; the input is ready only while idle.
// Reset: synchronous, active high; clears edge count, node_count, sequencer, not the store.
`default_nettype none

module topological_sort_kahn
   import tks_pkg::*;
#(
   parameter int MAX_EDGES = MAX_EDGES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [4:0] from_node, [9:5] to_node, rest zero
   input  wire logic [1:0]  req_tuser,   // [1:0] opcode
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [4:0] node_index, [5] cycle_error, rest zero
   output logic             rsp_tuser,   // [0] node_valid
   output logic             rsp_tlast,   // last
   // configuration port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;  // edge store index
   localparam int CW = $clog2(MAX_EDGES + 1);                    // edge count, in-degree

   // ---------------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------------
   state_type            state_ff, state_in;
   logic [COUNT_W-1:0]   node_count_ff;
   logic [COUNT_W-1:0]   n_ff, n_in;               // clamped node count of this sort
   logic [CW-1:0]        edge_total_ff, edge_total_in;
   logic [CW-1:0]        iss_ff, iss_in;           // next edge address to read
   logic                 rd_valid_ff, rd_valid_in; // read data below is live
   logic [NODE_W-1:0]    src_q_ff, dst_q_ff;       // registered edge store read
   logic [COUNT_W-1:0]   seed_ff, seed_in;         // node under the zero in-degree scan
   logic [COUNT_W-1:0]   depth_ff, depth_in;       // work stack depth
   logic [COUNT_W-1:0]   emitted_ff, emitted_in;
   logic [NODE_W-1:0]    cur_ff, cur_in;           // node being expanded
   logic [CW-1:0]        deg_ff   [MAX_NODES];
   logic [NODE_W-1:0]    stack_ff [MAX_NODES];

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0]    rsp_index_ff, rsp_index_in;
   logic                 rsp_nvalid_ff, rsp_nvalid_in;
   logic                 rsp_err_ff, rsp_err_in;
   logic                 rsp_last_ff, rsp_last_in;

   // edge store
   logic [NODE_W-1:0]    src_mem [MAX_EDGES];
   logic [NODE_W-1:0]    dst_mem [MAX_EDGES];

   // ---------------------------------------------------------------------------
   // Datapath controls
   // ---------------------------------------------------------------------------
   logic                 mem_we;
   logic                 deg_clear, deg_we;
   logic [NODE_W-1:0]    deg_addr;
   logic [CW-1:0]        deg_wdata, deg_rd;
   logic                 push;
   logic [NODE_W-1:0]    push_node;
   logic                 out_free;
   logic                 req_fire;
   opcode_type           opcode;
   logic [NODE_W-1:0]    from_node, to_node;
   logic                 scan_done;
   logic [NODE_W-1:0]    pop_idx;
   logic                 csr_wr;

   assign opcode    = opcode_type'(req_tuser);
   assign from_node = req_tdata[4:0];
   assign to_node   = req_tdata[9:5];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire  = req_tvalid && req_tready;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign scan_done = (iss_ff == edge_total_ff) && !rd_valid_ff;
   assign pop_idx   = NODE_W'(depth_ff - 1'b1);

   // the in-degree table has a single read address: the seed counter while
   // seeding, the target of the edge in flight otherwise
   assign deg_addr  = (state_ff == ST_SEED) ? seed_ff[NODE_W-1:0] : dst_q_ff;
   assign deg_rd    = deg_ff[deg_addr];

   // ---------------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      n_in          = n_ff;
      edge_total_in = edge_total_ff;
      iss_in        = iss_ff;
      rd_valid_in   = 1'b0;
      seed_in       = seed_ff;
      depth_in      = depth_ff;
      emitted_in    = emitted_ff;
      cur_in        = cur_ff;
      mem_we        = 1'b0;
      deg_clear     = 1'b0;
      deg_we        = 1'b0;
      deg_wdata     = deg_rd;
      push          = 1'b0;
      push_node     = dst_q_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_index_in  = rsp_index_ff;
      rsp_nvalid_in = rsp_nvalid_ff;
      rsp_err_in    = rsp_err_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (opcode)
                  OP_CLEAR: begin
                     edge_total_in = '0;
                  end
                  OP_ADD: begin
                     // drop the edge when the store is full
                     if (edge_total_ff < CW'(MAX_EDGES)) begin
                        mem_we        = 1'b1;
                        edge_total_in = edge_total_ff + 1'b1;
                     end
                  end
                  OP_SORT: begin
                     n_in       = (node_count_ff > COUNT_W'(MAX_NODES)) ?
                                  COUNT_W'(MAX_NODES) : node_count_ff;
                     deg_clear  = 1'b1;
                     depth_in   = '0;
                     emitted_in = '0;
                     iss_in     = '0;
                     state_in   = ST_COUNT;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_COUNT: begin
            // stream the edge list, one read a cycle, count in-range edges
            if (iss_ff < edge_total_ff) begin
               iss_in      = iss_ff + 1'b1;
               rd_valid_in = 1'b1;
            end
            if (rd_valid_ff && ({1'b0, src_q_ff} < n_ff) && ({1'b0, dst_q_ff} < n_ff)) begin
               deg_we    = 1'b1;
               deg_wdata = deg_rd + 1'b1;
            end
            if (scan_done) begin
               seed_in  = '0;
               state_in = ST_SEED;
            end
         end

         ST_SEED: begin
            // push zero in-degree nodes in ascending order
            if (seed_ff < n_ff) begin
               if (deg_rd == '0) begin
                  push      = 1'b1;
                  push_node = seed_ff[NODE_W-1:0];
               end
               seed_in = seed_ff + 1'b1;
            end else begin
               state_in = ST_POP;
            end
         end

         ST_POP: begin
            if (depth_ff == '0) begin
               state_in = ST_STATUS;
            end else if (out_free) begin
               depth_in      = depth_ff - 1'b1;
               cur_in        = stack_ff[pop_idx];
               emitted_in    = emitted_ff + 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_index_in  = stack_ff[pop_idx];
               rsp_nvalid_in = 1'b1;
               rsp_err_in    = 1'b0;
               rsp_last_in   = 1'b0;
               iss_in        = '0;
               state_in      = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // walk the edges out of the popped node in load order
            if (iss_ff < edge_total_ff) begin
               iss_in      = iss_ff + 1'b1;
               rd_valid_in = 1'b1;
            end
            if (rd_valid_ff && (src_q_ff == cur_ff) && ({1'b0, dst_q_ff} < n_ff) &&
                (deg_rd != '0)) begin
               deg_we    = 1'b1;
               deg_wdata = deg_rd - 1'b1;
               if (deg_rd == CW'(1)) begin
                  push = 1'b1;
               end
            end
            if (scan_done) begin
               state_in = ST_POP;
            end
         end

         ST_STATUS: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_index_in  = '0;
               rsp_nvalid_in = 1'b0;
               rsp_err_in    = (emitted_ff < n_ff);
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // push onto the work stack, drop it when full
      if (push && (depth_ff < COUNT_W'(MAX_NODES))) begin
         depth_in = depth_ff + 1'b1;
      end
   end

   // ---------------------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------------------
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         node_count_ff <= '0;
         edge_total_ff <= '0;
         iss_ff        <= '0;
         rd_valid_ff   <= 1'b0;
         depth_ff      <= '0;
         emitted_ff    <= '0;
         seed_ff       <= '0;
         n_ff          <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         edge_total_ff <= edge_total_in;
         iss_ff        <= iss_in;
         rd_valid_ff   <= rd_valid_in;
         depth_ff      <= depth_in;
         emitted_ff    <= emitted_in;
         seed_ff       <= seed_in;
         n_ff          <= n_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr && !csr_paddr[2]) begin
            node_count_ff <= csr_pwdata[COUNT_W-1:0];
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Payload registers, scratch tables and edge store
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_nvalid_ff <= rsp_nvalid_in;
      rsp_err_ff    <= rsp_err_in;
      rsp_last_ff   <= rsp_last_in;
      if (deg_clear) begin
         for (int i = 0; i < MAX_NODES; i++) begin
            deg_ff[i] <= '0;
         end
      end else if (deg_we) begin
         deg_ff[deg_addr] <= deg_wdata;
      end
      if (push && (depth_ff < COUNT_W'(MAX_NODES))) begin
         stack_ff[depth_ff[NODE_W-1:0]] <= push_node;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         src_mem[edge_total_ff[EW-1:0]] <= from_node;
         dst_mem[edge_total_ff[EW-1:0]] <= to_node;
      end
      src_q_ff <= src_mem[iss_ff[EW-1:0]];
      dst_q_ff <= dst_mem[iss_ff[EW-1:0]];
   end

   // ---------------------------------------------------------------------------
   // Outputs
   // ---------------------------------------------------------------------------
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_err_ff, rsp_index_ff};
   assign rsp_tuser  = rsp_nvalid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? 32'd0 : 32'(node_count_ff);

   // ---------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= COUNT_W'(MAX_NODES))
      else $error("work stack depth above node range");

   a_emit_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (emitted_ff <= n_ff))
      else $error("more nodes emitted than sorted");

   a_read_bound: assert property (@(posedge clock) disable iff (reset)
      iss_ff <= edge_total_ff || state_ff == ST_IDLE)
      else $error("edge read past stored edges");

   a_status_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP && depth_ff == '0) |=> (state_ff == ST_STATUS))
      else $error("empty stack did not end the sort");

endmodule

`default_nettype wire

### tb/tb.sv
//------------------------------------------------------------------------------
// tb
// Self-checking bench for the Kahn topological sort engine: loads edge sets
// over the request stream, programs node_count over the register port, runs
// sorts and checks every result beat against a local model of the sort.
//------------------------------------------------------------------------------
`default_nettype none

module tb;
   import tks_pkg::*;

   // Opcode 3 has no meaning for the block and must be dropped silently.
   localparam logic [1:0]  OP_UNUSED      = 2'd3;
   localparam logic [2:0]  CSR_NODE_COUNT = 3'd0;   // register 0 at byte 0
   localparam int          LINK_DEPTH     = MAX_EDGES_DEF;
   localparam int          RANDOM_ITEMS   = 270;
   // Clear and add-edge beats finish in the cycle after they are taken; a sort
   // is done once its status beat has left. The settle wait covers both.
   localparam int          SETTLE_CYCLES  = 8;
   localparam int          TAIL_CYCLES    = 100;
   // A run holds well under a hundred sorts, each walking every stored edge once
   // per pop and with at most 33 result beats waiting out receiver stalls; the
   // cap sits several times above the length of such a run.
   localparam int unsigned LIMIT_CYCLES   = 2_000_000;

   typedef struct packed {
      logic [NODE_W-1:0] node_index;
      logic              node_valid;
      logic              cycle_error;
      logic              last;
   } order_beat_type;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   //---------------------------------------------------------------------------
   // Scoreboard: keeps its own copy of the edge store and node_count, works out
   // the order beats of every sort it sees and checks what comes back.
   //---------------------------------------------------------------------------
   class sort_scoreboard_type;
      logic [COUNT_W-1:0] node_count;
      logic [NODE_W-1:0]  link_from[LINK_DEPTH];
      logic [NODE_W-1:0]  link_to[LINK_DEPTH];
      int unsigned        link_total;
      order_beat_type     expected_q[$];
      int unsigned        error_count;

      function new();
         node_count  = '0;
         link_total  = 0;
         error_count = 0;
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH: %s", msg);
         error_count++;
      endtask

      function void set_node_count(logic [COUNT_W-1:0] value);
         node_count = value;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Kahn's walk: seed the stack with zero in-degree nodes in ascending
      // order, pop from the top, scan links in load order on every pop.
      function void predict_order();
         int unsigned       span;
         int unsigned       depth;
         int unsigned       emitted;
         int unsigned       in_count[MAX_NODES];
         logic [NODE_W-1:0] stack[MAX_NODES];
         logic [NODE_W-1:0] node;
         logic [NODE_W-1:0] target;
         order_beat_type    beat;

         span    = (node_count > MAX_NODES) ? MAX_NODES : node_count;
         depth   = 0;
         emitted = 0;
         for (int i = 0; i < MAX_NODES; i++) in_count[i] = 0;
         for (int k = 0; k < link_total; k++) begin
            // links touching a node outside the range take no part
            if (link_from[k] < span && link_to[k] < span) in_count[link_to[k]]++;
         end
         for (int i = 0; i < span; i++) begin
            if (in_count[i] == 0 && depth < MAX_NODES) begin
               stack[depth] = NODE_W'(i);
               depth++;
            end
         end
         while (depth > 0) begin
            depth--;
            node = stack[depth];
            beat = '{node_index: node, node_valid: 1'b1, cycle_error: 1'b0, last: 1'b0};
            expected_q.insert(expected_q.size(), beat);
            emitted++;
            for (int k = 0; k < link_total; k++) begin
               target = link_to[k];
               if (link_from[k] == node && target < span && in_count[target] > 0) begin
                  in_count[target]--;
                  if (in_count[target] == 0 && depth < MAX_NODES) begin
                     stack[depth] = target;
                     depth++;
                  end
               end
            end
         end
         // status beat: flag a cycle when some nodes never reached zero
         beat = '{node_index: '0, node_valid: 1'b0, cycle_error: (emitted < span),
                  last: 1'b1};
         expected_q.insert(expected_q.size(), beat);
      endfunction

      function void note_request(logic [1:0] op, logic [NODE_W-1:0] src,
                                 logic [NODE_W-1:0] dst);
         case (op)
            OP_CLEAR: link_total = 0;
            OP_ADD: begin
               // a full store drops the link
               if (link_total < LINK_DEPTH) begin
                  link_from[link_total] = src;
                  link_to[link_total]   = dst;
                  link_total++;
               end
            end
            OP_SORT: predict_order();
            default: ;
         endcase
      endfunction

      task check_result(order_beat_type got);
         order_beat_type want;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf({"result beat with nothing expected: ",
                                       "idx %0d v %0b c %0b l %0b"},
                                      got.node_index, got.node_valid, got.cycle_error,
                                      got.last));
            return;
         end
         want = expected_q.pop_front();
         if (got.node_index !== want.node_index)
            report_mismatch($sformatf("node_index got %0d want %0d",
                                      got.node_index, want.node_index));
         if (got.node_valid !== want.node_valid)
            report_mismatch($sformatf("node_valid got %0b want %0b",
                                      got.node_valid, want.node_valid));
         if (got.cycle_error !== want.cycle_error)
            report_mismatch($sformatf("cycle_error got %0b want %0b",
                                      got.cycle_error, want.cycle_error));
         if (got.last !== want.last)
            report_mismatch($sformatf("last got %0b want %0b", got.last, want.last));
      endtask

      task check_drained();
         if (expected_q.size() != 0)
            report_mismatch($sformatf("%0d result beats never arrived", expected_q.size()));
      endtask
   endclass

   //---------------------------------------------------------------------------
   // Clock, reset and the block
   //---------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;     // [4:0] from_node, [9:5] to_node, rest zero
   logic [1:0]  req_tuser = OP_CLEAR; // [1:0] opcode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;          // [4:0] node_index, [5] cycle_error, rest zero
   logic        rsp_tuser;          // [0] node_valid
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   idle_mode_type       idle_mode = IDLE_NONE;
   sort_scoreboard_type sb;
   int unsigned         items_sent = 0;
   int unsigned         cycle_count = 0;

   always #6 clock = ~clock;

   topological_sort_kahn dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Draw one idle decision for the sender or the receiver in the current phase.
   function automatic bit draw_idle(bit on_sender);
      int unsigned percent;
      case (idle_mode)
         IDLE_SENDER:   percent = on_sender ? 81 : 0;
         IDLE_RECEIVER: percent = on_sender ? 0 : 81;
         IDLE_BOTH:     percent = 36;
         default:       percent = 0;
      endcase
      return $urandom_range(0, 99) < percent;
   endfunction

   //---------------------------------------------------------------------------
   // Receiver: sample the result beat at the edge, then draw the next tready.
   // Values read here are the ones from before the edge.
   //---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result('{node_index: rsp_tdata[4:0], node_valid: rsp_tuser,
                           cycle_error: rsp_tdata[5], last: rsp_tlast});
      rsp_tready <= !draw_idle(1'b0);
   end

   // Watchdog: end a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("Some tests failed");
         $finish;
      end
   end

   //---------------------------------------------------------------------------
   // Drivers
   //---------------------------------------------------------------------------

   // Offer one request beat and hold it until taken. tvalid stays high after
   // the handshake so that back-to-back beats never lower and raise it in the
   // same step; the next call or a drain decides what it does next.
   task automatic send_beat(logic [1:0] op, logic [NODE_W-1:0] src,
                            logic [NODE_W-1:0] dst);
      while (draw_idle(1'b1)) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {6'b0, dst, src};
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, src, dst);
      if (op != OP_UNUSED) items_sent++;
   endtask

   // Drop tvalid and hold off until every expected beat is back, then let the
   // block settle so the next register write lands while it is idle.
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write node_count, then read it back.
   task automatic write_node_count(logic [COUNT_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_NODE_COUNT;
      csr_pwdata  <= {26'b0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_node_count(value);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== {26'b0, value})
         sb.report_mismatch($sformatf("node_count read back %0d, wrote %0d",
                                      csr_prdata, value));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Add one random link: mostly forward links inside the node range (these
   // give long orders), some arbitrary ones inside the range (cycles), some
   // repeats of the previous link and some anywhere in the index space.
   // Now and then a stray opcode-3 beat goes in first.
   task automatic add_random_link(int unsigned span, inout logic [NODE_W-1:0] src,
                                  inout logic [NODE_W-1:0] dst);
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if ($urandom_range(0, 15) == 0)
         send_beat(OP_UNUSED, NODE_W'($urandom), NODE_W'($urandom));
      if (span < 2 || pick == 9) begin
         src = NODE_W'($urandom_range(0, 31));
         dst = NODE_W'($urandom_range(0, 31));
      end else if (pick <= 5) begin
         src = NODE_W'($urandom_range(0, span - 2));
         dst = NODE_W'($urandom_range(src + 1, span - 1));
      end else if (pick <= 7) begin
         src = NODE_W'($urandom_range(0, span - 1));
         dst = NODE_W'($urandom_range(0, span - 1));
      end
      // pick 8 keeps the previous link: a duplicate counts twice
      send_beat(OP_ADD, src, dst);
   endtask

   // One graph: program node_count, usually clear, load links, sort, and
   // sometimes grow the graph and sort again. A fill episode loads past the
   // store depth at the full node count.
   task automatic run_episode(bit fill_store);
      int unsigned       count_value;
      int unsigned       span;
      int unsigned       link_count;
      logic [NODE_W-1:0] src;
      logic [NODE_W-1:0] dst;

      wait_drain();
      if (fill_store) begin
         count_value = MAX_NODES;
      end else begin
         case ($urandom_range(0, 9))
            0:       count_value = 0;
            1:       count_value = MAX_NODES;
            2:       count_value = 1;
            3:       count_value = $urandom_range(MAX_NODES + 1, 63);
            default: count_value = $urandom_range(2, 12);
         endcase
      end
      write_node_count(COUNT_W'(count_value));
      span = (count_value > MAX_NODES) ? MAX_NODES : count_value;

      if (!fill_store && $urandom_range(0, 3) != 0)
         send_beat(OP_CLEAR, NODE_W'($urandom), NODE_W'($urandom));
      link_count = fill_store ? LINK_DEPTH + 6 : $urandom_range(1, 14);
      src = '0;
      dst = '0;
      for (int k = 0; k < link_count; k++) add_random_link(span, src, dst);
      send_beat(OP_SORT, NODE_W'($urandom), NODE_W'($urandom));

      if ($urandom_range(0, 2) == 0) begin
         repeat ($urandom_range(1, 4)) add_random_link(span, src, dst);
         send_beat(OP_SORT, NODE_W'($urandom), NODE_W'($urandom));
      end
   endtask

   //---------------------------------------------------------------------------
   // Main sequence
   //---------------------------------------------------------------------------
   initial begin
      int unsigned base;
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part, no idling.
      // Opcode 3 with all payload bits set: dropped, no result.
      send_beat(OP_UNUSED, 5'd31, 5'd31);
      // node_count is 0 out of reset: empty graph, status beat only.
      send_beat(OP_SORT, 5'd0, 5'd0);

      wait_drain();
      write_node_count(COUNT_W'(MAX_NODES));
      // 0 <-> 31 is a cycle; 5 -> 6 loaded twice needs both links released.
      send_beat(OP_ADD, 5'd0, 5'd31);
      send_beat(OP_ADD, 5'd31, 5'd0);
      send_beat(OP_ADD, 5'd5, 5'd6);
      send_beat(OP_ADD, 5'd5, 5'd6);
      send_beat(OP_ADD, 5'd10, 5'd21);
      send_beat(OP_SORT, 5'd31, 5'd31);
      // Clear and load a chain across the whole index range.
      send_beat(OP_CLEAR, 5'd31, 5'd31);
      send_beat(OP_ADD, 5'd31, 5'd0);
      send_beat(OP_ADD, 5'd0, 5'd16);
      send_beat(OP_ADD, 5'd16, 5'd15);
      send_beat(OP_SORT, 5'd0, 5'd0);

      // Out-of-range count is clamped to the node limit.
      wait_drain();
      write_node_count(COUNT_W'(40));
      send_beat(OP_SORT, 5'd0, 5'd0);

      // Four nodes: links touching node 9 fall outside and are skipped.
      wait_drain();
      write_node_count(COUNT_W'(4));
      send_beat(OP_CLEAR, 5'd0, 5'd0);
      send_beat(OP_ADD, 5'd2, 5'd9);
      send_beat(OP_ADD, 5'd9, 5'd2);
      send_beat(OP_ADD, 5'd3, 5'd1);
      send_beat(OP_ADD, 5'd1, 5'd0);
      send_beat(OP_SORT, 5'd0, 5'd0);

      // Zero nodes with links stored: still just the status beat.
      wait_drain();
      write_node_count('0);
      send_beat(OP_SORT, 5'd0, 5'd0);

      // Random part in four idling phases. Every episode starts by draining,
      // so the sender regularly holds off until all results are back.
      base = items_sent;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       idle_mode <= IDLE_NONE;
            1:       idle_mode <= IDLE_SENDER;
            2:       idle_mode <= IDLE_RECEIVER;
            default: idle_mode <= IDLE_BOTH;
         endcase
         // fill the edge store once, early in the sender-idle phase
         run_episode(phase == 1);
         while (items_sent - base < (phase + 1) * RANDOM_ITEMS / 4) run_episode(1'b0);
      end

      // Drain, give a stray beat time to show up, then judge.
      wait_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      sb.check_drained();
      if (sb.error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire
